// ----- design/fkect_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: shared package
// Widths of the item fields, controller states and the command and status
// groups that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package fkect_pkg;

    // Widths of the request and response fields.
    localparam int KEY_W  = 31;
    localparam int SLOT_W = 4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIST,
        ST_DECIDE,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // Latch the request key and clear the scan results.
        logic issue;   // Read the next stored key.
        logic gap;     // Form the distances to both eviction candidates.
        logic decide;  // Pick the slot and the victim.
        logic commit;  // Update the tag store and load the response.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;       // No slot holds a key yet.
        logic last_issue;  // The read address is the last filled slot.
        logic out_free;    // The response register can take a new item.
    } t_dp_sts;

endpackage

// ----- design/fkect_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: channel interfaces
// Request channel with the line number and response channel with the
// lookup result, both with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface fkect_req_if;
    import fkect_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] line_number;

    modport source (output valid, output line_number, input ready);
    modport sink   (input valid, input line_number, output ready);
endinterface

interface fkect_rsp_if;
    import fkect_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_line;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_line, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_line, output ready);
endinterface

// ----- design/fkect_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fkect_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fkect_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: datapath
// Holds the tag RAM and the fill count, scans the stored keys one per cycle
// for a match and for the smallest nonzero and largest key, chooses the
// victim and holds the response register.
// ---------------------------------------------------------------------------
module fkect_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fkect_pkg::t_dp_cmd            i_cmd,
    output fkect_pkg::t_dp_sts            o_sts,
    input  logic [fkect_pkg::KEY_W-1:0]   i_line_number,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic                          o_hit,
    output logic [fkect_pkg::SLOT_W-1:0]  o_slot,
    output logic                          o_evicted,
    output logic [fkect_pkg::KEY_W-1:0]   o_evicted_line
);
    import fkect_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Request and fill state.
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic             full;

    // Scan pipeline.
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_dv;
    logic             r_dv_first;
    logic [IDX_W-1:0] r_dv_idx;
    logic [KEY_W-1:0] rd_key;

    // Scan results.
    logic             r_found;
    logic [IDX_W-1:0] r_hit_slot;
    logic [KEY_W-1:0] r_hi_key;
    logic [IDX_W-1:0] r_hi_slot;
    logic             r_have_lo;
    logic [KEY_W-1:0] r_lo_key;
    logic [IDX_W-1:0] r_lo_slot;

    // Distances and decision.
    logic [KEY_W-1:0] r_dist_lo;
    logic [KEY_W-1:0] r_dist_hi;
    logic [IDX_W-1:0] r_sel_slot;
    logic             r_ev;
    logic [KEY_W-1:0] r_ev_line;

    // Response register.
    logic              r_o_valid;
    logic              r_o_hit;
    logic [SLOT_W-1:0] r_o_slot;
    logic              r_o_ev;
    logic [KEY_W-1:0]  r_o_ev_line;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign full = (r_count == CNT_W'(CAPACITY));

    // Tag store.
    fkect_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && !r_found),
        .i_waddr (r_sel_slot),
        .i_wdata (r_key),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_key)
    );

    // Status to the controller.
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.last_issue = (CNT_W'(r_rd_idx) == r_count - CNT_W'(1));
    assign o_sts.out_free   = !r_o_valid || i_rsp_ready;

    // Request key, read address and read-data tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= i_cmd.issue;
        end
        if (i_cmd.start) begin
            r_key    <= i_line_number;
            r_rd_idx <= '0;
        end else if (i_cmd.issue) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
        r_dv_first <= (r_rd_idx == '0);
        r_dv_idx   <= r_rd_idx;
    end

    // Match, largest key and smallest nonzero key over the scanned slots.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_found   <= 1'b0;
            r_have_lo <= 1'b0;
        end else if (r_dv) begin
            if (!r_found && rd_key == r_key) begin
                r_found    <= 1'b1;
                r_hit_slot <= r_dv_idx;
            end
            if (r_dv_first || rd_key > r_hi_key) begin
                r_hi_key  <= rd_key;
                r_hi_slot <= r_dv_idx;
            end
            if (rd_key != '0 && (!r_have_lo || rd_key < r_lo_key)) begin
                r_have_lo <= 1'b1;
                r_lo_key  <= rd_key;
                r_lo_slot <= r_dv_idx;
            end
        end
    end

    // Distances from the request to both candidates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.gap) begin
            r_dist_lo <= (r_key >= r_lo_key) ? r_key - r_lo_key : r_lo_key - r_key;
            r_dist_hi <= (r_hi_key >= r_key) ? r_hi_key - r_key : r_key - r_hi_key;
        end
    end

    // Slot choice: the hit slot, the lowest free slot or the farther victim.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            if (r_found) begin
                r_sel_slot <= r_hit_slot;
                r_ev       <= 1'b0;
                r_ev_line  <= '0;
            end else if (!full) begin
                r_sel_slot <= r_count[IDX_W-1:0];
                r_ev       <= 1'b0;
                r_ev_line  <= '0;
            end else if (r_have_lo && r_dist_lo >= r_dist_hi) begin
                r_sel_slot <= r_lo_slot;
                r_ev       <= 1'b1;
                r_ev_line  <= r_lo_key;
            end else begin
                r_sel_slot <= r_hi_slot;
                r_ev       <= 1'b1;
                r_ev_line  <= r_hi_key;
            end
        end
    end

    // Fill count grows by one for each miss that lands in a free slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit && !r_found && !full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, r_sel_slot};

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_o_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_o_hit     <= r_found;
            r_o_slot    <= slot_ext[SLOT_W-1:0];
            r_o_ev      <= r_ev;
            r_o_ev_line <= r_ev_line;
        end
    end

    assign o_rsp_valid    = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_slot         = r_o_slot;
    assign o_evicted      = r_o_ev;
    assign o_evicted_line = r_o_ev_line;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    // An eviction is committed only when every slot is filled.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_ev |-> full && !r_found)
        else $error("eviction with a free slot or on a hit");

    // A hit response never reports an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_hit |-> !r_o_ev)
        else $error("hit response carries an eviction");

endmodule

// ----- design/fkect_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: controller
// Sequences one request through the scan of the filled slots, the distance
// and decision steps and the commit into the response register.
// ---------------------------------------------------------------------------
module fkect_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  fkect_pkg::t_dp_sts i_sts,
    output fkect_pkg::t_dp_cmd o_cmd
);
    import fkect_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_sts.empty ? ST_DIST : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DIST;
            ST_DIST:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_COMMIT;
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.start = i_req_valid;
            end
            ST_SCAN:   o_cmd.issue  = 1'b1;
            ST_DIST:   o_cmd.gap    = 1'b1;
            ST_DECIDE: o_cmd.decide = 1'b1;
            ST_COMMIT: o_cmd.commit = i_sts.out_free;
            default: begin
                o_cmd       = '0;
                o_req_ready = 1'b0;
            end
        endcase
    end

    // A commit never overwrites a response that is still waiting.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while the response register is busy");

    // A request accepted into an empty table skips the scan.
    a_empty_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start && i_sts.empty |=> r_state == ST_DIST)
        else $error("scan started on an empty table");

    // The scan always ends through the drain step.
    a_scan_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN && i_sts.last_issue |=> r_state == ST_DRAIN)
        else $error("scan did not end in the drain step");

endmodule

// ----- design/farthest_key_eviction_cache_tags_top.sv -----
`timescale 1ns / 1ps
// From request acceptance to response valid a request passes the scan of the filled slots,
// in which the tag RAM read port reads one stored key per cycle, and the drain step after it;
// an empty table skips both. The distance, decision and commit steps follow.
// Requests are handled one at a time; a new request is taken while the previous response
// waits, and its commit waits for that response.
// Reset clears the fill count, which marks every slot empty, the response valid and the FSM.
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: top level
// Tag lookup with lowest-free-slot fill and farthest-key eviction.
// ---------------------------------------------------------------------------
module farthest_key_eviction_cache_tags_top #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fkect_req_if.sink   i_req,
    fkect_rsp_if.source o_rsp
);
    import fkect_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller.
    fkect_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath.
    fkect_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_line_number  (i_req.line_number),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_hit          (o_rsp.hit),
        .o_slot         (o_rsp.slot),
        .o_evicted      (o_rsp.evicted),
        .o_evicted_line (o_rsp.evicted_line)
    );

endmodule

// ----- test/fkect_lookup_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: lookup checker
// Watches the request and response channels, keeps its own copy of the tag
// store, predicts the result of every accepted request and compares each
// accepted response field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module fkect_lookup_checker #(
    parameter int CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fkect_req_if  i_req,
    fkect_rsp_if  i_rsp,
    output int    o_fail_cnt,
    output int    o_pending
);
    import fkect_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_line;
    } t_lookup;

    // Mirror of the tag store.
    logic [KEY_W-1:0] tag_key   [CAPACITY];
    logic             tag_valid [CAPACITY];

    // Predicted responses, oldest first.
    t_lookup expected_lookups[$];

    int fail_cnt = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        fail_cnt++;
        $display("%0t ns: lookup mismatch: %s", $time, what);
    endtask

    // Looks the key up in the mirror, applies fill or eviction and returns
    // the response that the block must give.
    function automatic t_lookup predict_lookup(input logic [KEY_W-1:0] key);
        t_lookup          res;
        int               found_at;
        int               free_at;
        int               lo_at;
        int               hi_at;
        int               victim;
        logic [KEY_W-1:0] lo_key;
        logic [KEY_W-1:0] hi_key;
        logic [KEY_W-1:0] lo_gap;
        logic [KEY_W-1:0] hi_gap;

        res      = '0;
        found_at = -1;
        free_at  = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (tag_valid[i] && tag_key[i] == key && found_at < 0) begin
                found_at = i;
            end
            if (!tag_valid[i] && free_at < 0) begin
                free_at = i;
            end
        end

        if (found_at >= 0) begin
            res.hit  = 1'b1;
            res.slot = found_at[SLOT_W-1:0];
            return res;
        end

        if (free_at >= 0) begin
            victim = free_at;
        end else begin
            // Full table: the smallest nonzero key and the largest key are
            // the candidates; key 0 is never a low candidate.
            lo_at  = -1;
            lo_key = '0;
            hi_at  = 0;
            hi_key = tag_key[0];
            for (int i = 0; i < CAPACITY; i++) begin
                if (tag_key[i] > hi_key) begin
                    hi_key = tag_key[i];
                    hi_at  = i;
                end
                if (tag_key[i] != '0 && (lo_at < 0 || tag_key[i] < lo_key)) begin
                    lo_key = tag_key[i];
                    lo_at  = i;
                end
            end
            lo_gap = (key >= lo_key) ? key - lo_key : lo_key - key;
            hi_gap = (hi_key >= key) ? hi_key - key : key - hi_key;
            // The farther candidate goes; a tie evicts the smaller key.
            if (lo_at >= 0 && lo_gap >= hi_gap) begin
                victim           = lo_at;
                res.evicted_line = lo_key;
            end else begin
                victim           = hi_at;
                res.evicted_line = hi_key;
            end
            res.evicted = 1'b1;
        end

        tag_key[victim]   = key;
        tag_valid[victim] = 1'b1;
        res.slot          = victim[SLOT_W-1:0];
        return res;
    endfunction

    // Compare responses first, then predict for the request of this edge.
    always @(posedge i_clk) begin
        t_lookup want;

        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                tag_valid[i] = 1'b0;
            end
            expected_lookups.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("response item with no request pending");
                end else begin
                    want = expected_lookups.pop_front();
                    if (i_rsp.hit !== want.hit) begin
                        report_mismatch($sformatf("hit got %0b want %0b",
                                                  i_rsp.hit, want.hit));
                    end
                    if (i_rsp.slot !== want.slot) begin
                        report_mismatch($sformatf("slot got %0d want %0d",
                                                  i_rsp.slot, want.slot));
                    end
                    if (i_rsp.evicted !== want.evicted) begin
                        report_mismatch($sformatf("evicted got %0b want %0b",
                                                  i_rsp.evicted, want.evicted));
                    end
                    if (i_rsp.evicted_line !== want.evicted_line) begin
                        report_mismatch($sformatf("evicted_line got %0d want %0d",
                                                  i_rsp.evicted_line,
                                                  want.evicted_line));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_lookups.insert(expected_lookups.size(),
                                        predict_lookup(i_req.line_number));
            end
        end
        o_pending  <= expected_lookups.size();
        o_fail_cnt <= fail_cnt;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Farthest-key eviction cache tags: testbench top
// Drives line-number requests (a directed fill and eviction sequence, then
// random keys from wide, narrow and recently used ranges) with random gaps
// and response stalls, and gives the verdict from the lookup checker.
// ---------------------------------------------------------------------------
module tb_top;
    import fkect_pkg::*;

    localparam int               CAPACITY    = 16;
    localparam int               RANDOM_REQS = 1750;
    localparam logic [KEY_W-1:0] KEY_MAX     = {KEY_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n;

    // Set while both sides run without any idling.
    logic quiet_phase = 1'b0;
    int   items_sent  = 0;
    int   fail_cnt;
    int   pending;

    logic [KEY_W-1:0] recent_lines[$];

    fkect_req_if req_ch ();
    fkect_rsp_if rsp_ch ();

    farthest_key_eviction_cache_tags_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    fkect_lookup_checker #(
        .CAPACITY (CAPACITY)
    ) checker_inst (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always #6 clk = ~clk;

    // Offers one request item, after a random gap, and waits for acceptance.
    task automatic offer_line(input logic [KEY_W-1:0] key);
        while (!quiet_phase && $urandom_range(99) < 13) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.line_number <= key;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        items_sent++;
        recent_lines.insert(recent_lines.size(), key);
        if (recent_lines.size() > 24) begin
            void'(recent_lines.pop_front());
        end
    endtask

    // Request side: directed part, random part, drain and verdict.
    initial begin : request_source
        logic [KEY_W-1:0] opening_keys[$];
        logic [KEY_W-1:0] key;
        int               roll;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.line_number = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Key 0, a hit on it, the largest key, a fill to full, then evictions
        // of the high candidate, of the low one, a tie, and a hit when full.
        opening_keys = '{31'd0, 31'd0, KEY_MAX,
                         31'd100, 31'd200, 31'd300, 31'd400, 31'd500, 31'd600,
                         31'd700, 31'd800, 31'd900, 31'd1000, 31'd1100,
                         31'd1200, 31'd1300, 31'd1400,
                         31'd750, 31'd750, 31'd1450, 31'd825, 31'd1, 31'd0,
                         KEY_MAX};
        foreach (opening_keys[i]) begin
            offer_line(opening_keys[i]);
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            quiet_phase = (n >= 700 && n < 1000);
            roll        = $urandom_range(99);
            if (n >= 1000 && n < 1400) begin
                // Narrow keys keep both candidates close, so ties and hits
                // come often.
                key = KEY_W'($urandom_range(40));
            end else if (roll < 40 && recent_lines.size() > 0) begin
                key = recent_lines[$urandom_range(recent_lines.size() - 1)];
            end else if (roll < 60) begin
                key = KEY_W'($urandom());
            end else if (roll < 80) begin
                key = KEY_W'($urandom_range(3000));
            end else if (roll < 92) begin
                key = KEY_MAX - KEY_W'($urandom_range(3000));
            end else begin
                case ($urandom_range(2))
                    0:       key = '0;
                    1:       key = 31'd1;
                    default: key = KEY_MAX;
                endcase
            end
            offer_line(key);
        end
        quiet_phase = 1'b0;
        req_ch.valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Response side: random stalls and one long hold-off that backs the
    // block up into its request channel.
    initial begin : response_sink
        logic held_off;
        int   hold_cycles;

        held_off     = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (!held_off && items_sent >= 300) begin
                held_off     = 1'b1;
                rsp_ch.ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) begin
                    @(posedge clk);
                end
            end else begin
                rsp_ch.ready <= quiet_phase || ($urandom_range(99) >= 13);
                @(posedge clk);
            end
        end
    end

    // Watchdog for a hung run.
    initial begin : watchdog
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/fkect_pkg.sv
design/fkect_if.sv
design/fkect_ram.sv
design/fkect_dp.sv
design/fkect_ctrl.sv
design/farthest_key_eviction_cache_tags_top.sv
test/fkect_lookup_checker.sv
test/tb_top.sv
